[src/opcs_pkg.sv]
// Shared types, command codes and constants of the output pattern command sequencer.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package opcs_pkg;

    localparam int CHANNELS    = 6;
    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W       = $clog2(CHANNELS);
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CMD_W       = 8;
    localparam int TIME_W      = 10;
    localparam int CFG_IDX_W   = 3;

    // Command byte codes.
    localparam logic [CMD_W-1:0] CMD_ALL_OFF  = 8'h00;
    localparam logic [CMD_W-1:0] CMD_PULSE_LO = 8'h01;
    localparam logic [CMD_W-1:0] CMD_PULSE_HI = CMD_W'(CHANNELS);
    localparam logic [CMD_W-1:0] CMD_CHASE    = 8'h10;
    localparam logic [CMD_W-1:0] CMD_BOUNCE   = 8'h11;
    localparam logic [CMD_W-1:0] CMD_FLASH    = 8'h12;
    localparam logic [CMD_W-1:0] CMD_SHUTDOWN = 8'h20;
    localparam logic [CMD_W-1:0] CMD_STARTUP  = 8'h21;
    localparam logic [CMD_W-1:0] CMD_UNMUTE   = 8'h22;
    localparam logic [CMD_W-1:0] CMD_MUTE     = 8'h23;

    localparam logic [2:0] CHASE_ROUNDS  = 3'd4;
    localparam logic [2:0] BOUNCE_ROUNDS = 3'd3;
    localparam logic [2:0] FLASH_COUNT   = 3'd5;

    localparam logic [IDX_W-1:0] CH_LAST = IDX_W'(CHANNELS - 1);
    localparam logic [IDX_W-1:0] CH_TURN = IDX_W'(CHANNELS - 2);

    // Register reset values.
    localparam logic [TIME_W-1:0] PULSE_MS_RST    = 10'd500;
    localparam logic [TIME_W-1:0] CHASE_ON_MS_RST = 10'd180;
    localparam logic [TIME_W-1:0] CHASE_GAP_RST   = 10'd70;
    localparam logic [TIME_W-1:0] BOUNCE_MS_RST   = 10'd140;
    localparam logic [TIME_W-1:0] FLASH_MS_RST    = 10'd300;
    localparam logic [TIME_W-1:0] SHUT_MS_RST     = 10'd10;
    localparam logic [TIME_W-1:0] SETTLE_MS_RST   = 10'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_MS     = 3'd0,
        CFG_CHASE_ON_MS  = 3'd1,
        CFG_CHASE_GAP_MS = 3'd2,
        CFG_BOUNCE_MS    = 3'd3,
        CFG_FLASH_MS     = 3'd4,
        CFG_SHUT_MS      = 3'd5,
        CFG_SETTLE_MS    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_W-1:0] pulse_ms;
        logic [TIME_W-1:0] chase_on_ms;
        logic [TIME_W-1:0] chase_gap_ms;
        logic [TIME_W-1:0] bounce_ms;
        logic [TIME_W-1:0] flash_ms;
        logic [TIME_W-1:0] mute_to_shutdown_ms;
        logic [TIME_W-1:0] startup_settle_ms;
    } t_cfg;

    // Decoded command as it is held in the queue.
    typedef enum logic [2:0] {
        OP_PULSE,
        OP_CHASE,
        OP_BOUNCE,
        OP_FLASH,
        OP_SHUT,
        OP_START,
        OP_UNMUTE,
        OP_MUTE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] chan;
    } t_qent;

    // Queue head as the back end sees it.
    typedef struct packed {
        logic  avail;
        t_qent entry;
    } t_qhead;

    typedef enum logic [2:0] {
        M_IDLE,
        M_PULSE,
        M_CHASE,
        M_BOUNCE,
        M_FLASH,
        M_SHUT,
        M_START
    } t_mode;

    // Line levels and flags reported by the back end.
    typedef struct packed {
        logic [CHANNELS-1:0] channel_drive;
        logic                amp_enable;
        logic                amp_mute;
        logic                busy_res;
        logic                unmute_refused;
    } t_lines;

    function automatic logic [CHANNELS-1:0] chan_bit(input logic [IDX_W-1:0] idx);
        logic [CHANNELS-1:0] b;
        for (int i = 0; i < CHANNELS; i++) begin
            b[i] = (idx == IDX_W'(i));
        end
        return b;
    endfunction

    // A phase of zero ticks lasts one tick.
    function automatic logic [TIME_W-1:0] load_time(input logic [TIME_W-1:0] d);
        return (d == '0) ? TIME_W'(1) : d;
    endfunction

endpackage

[src/opcs_in_if.sv]
// Input channel of the sequencer: command bytes and millisecond ticks.
// Depends on opcs_pkg for field widths.
`timescale 1ns / 1ps

interface opcs_in_if import opcs_pkg::*;;
    logic             valid;
    logic             ready;
    logic             func;
    logic [CMD_W-1:0] command;
    logic             fault_ok;

    modport source (output valid, output func, output command, output fault_ok,
                    input ready);
    modport sink   (input valid, input func, input command, input fault_ok,
                    output ready);
endinterface

[src/opcs_out_if.sv]
// Result channel of the sequencer: output line levels and event flags.
// Depends on opcs_pkg for field widths.
`timescale 1ns / 1ps

interface opcs_out_if import opcs_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CHANNELS-1:0] channel_drive;
    logic                amp_enable;
    logic                amp_mute;
    logic                busy_res;
    logic                unmute_refused;
    logic                command_dropped;

    modport source (output valid, output channel_drive, output amp_enable,
                    output amp_mute, output busy_res, output unmute_refused,
                    output command_dropped, input ready);
    modport sink   (input valid, input channel_drive, input amp_enable,
                    input amp_mute, input busy_res, input unmute_refused,
                    input command_dropped, output ready);
endinterface

[src/opcs_front.sv]
// Front end: classifies a command byte into a queue entry or rejects it as unknown.
// Depends on opcs_pkg.
`timescale 1ns / 1ps

module opcs_front import opcs_pkg::*; (
    input  logic [CMD_W-1:0] i_command,
    output logic             o_known,
    output t_qent            o_entry
);

    always_comb begin
        o_known       = 1'b1;
        o_entry.op    = OP_MUTE;
        o_entry.chan  = IDX_W'(i_command - CMD_PULSE_LO);
        case (i_command) inside
            [CMD_PULSE_LO:CMD_PULSE_HI]: o_entry.op = OP_PULSE;
            CMD_CHASE:                   o_entry.op = OP_CHASE;
            CMD_BOUNCE:                  o_entry.op = OP_BOUNCE;
            CMD_FLASH:                   o_entry.op = OP_FLASH;
            CMD_ALL_OFF, CMD_SHUTDOWN:   o_entry.op = OP_SHUT;
            CMD_STARTUP:                 o_entry.op = OP_START;
            CMD_UNMUTE:                  o_entry.op = OP_UNMUTE;
            CMD_MUTE:                    o_entry.op = OP_MUTE;
            default:                     o_known    = 1'b0;
        endcase
    end

endmodule

[src/opcs_queue.sv]
// Command queue between front and back end, with a bypass when it is empty.
// Depends on opcs_pkg.
`timescale 1ns / 1ps

module opcs_queue import opcs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qent  i_push_entry,
    input  logic   i_pop,
    output t_qhead o_head,
    output logic   o_dropped
);

    t_qent             r_mem [QUEUE_DEPTH];
    t_qent             r_rd;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              w_full;
    logic              w_write;

    assign w_full    = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign w_write   = i_push && !w_full;
    assign o_dropped = i_push && w_full;

    // An entry pushed into an empty queue can be taken in the same beat.
    assign o_head.avail = (r_fill != '0) || w_write;
    assign o_head.entry = (r_fill == '0) ? i_push_entry : r_rd;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (w_write) begin
            n_tail = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
        end
        if (i_pop) begin
            n_head = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
        end
        if (w_write && !i_pop) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (!w_write && i_pop) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // The entry at the next head is read ahead; a write into that slot passes through.
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[r_tail] <= i_push_entry;
        end
        if (w_write && (r_tail == n_head)) begin
            r_rd <= i_push_entry;
        end else begin
            r_rd <= r_mem[n_head];
        end
    end

endmodule

[src/opcs_back.sv]
// Back end: timed pattern engine and amplifier control, starting queued commands.
// Depends on opcs_pkg.
`timescale 1ns / 1ps

module opcs_back import opcs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_step,
    input  logic   i_tick,
    input  logic   i_fault_ok,
    input  t_cfg   i_cfg,
    input  t_qhead i_head,
    output logic   o_pop,
    output t_lines o_lines
);

    t_mode               r_mode, n_mode;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [2:0]          r_round, n_round;
    logic                r_phase, n_phase;
    logic [TIME_W-1:0]   r_time, n_time;
    logic [CHANNELS-1:0] r_bits, n_bits;
    logic                r_amp, n_amp;
    logic                r_mute, n_mute;
    logic                w_refused;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_idx   <= '0;
            r_round <= '0;
            r_phase <= 1'b0;
            r_time  <= '0;
            r_bits  <= '0;
            r_amp   <= 1'b0;
            r_mute  <= 1'b1;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_idx   <= n_idx;
            r_round <= n_round;
            r_phase <= n_phase;
            r_time  <= n_time;
            r_bits  <= n_bits;
            r_amp   <= n_amp;
            r_mute  <= n_mute;
        end
    end

    always_comb begin
        logic             v_done;
        logic [IDX_W-1:0] v_idx;
        logic [2:0]       v_rnd;

        n_mode    = r_mode;
        n_idx     = r_idx;
        n_round   = r_round;
        n_phase   = r_phase;
        n_time    = r_time;
        n_bits    = r_bits;
        n_amp     = r_amp;
        n_mute    = r_mute;
        w_refused = 1'b0;
        o_pop     = 1'b0;
        v_done    = 1'b0;
        v_idx     = r_idx;
        v_rnd     = r_round;

        // Advance the running action on a tick.
        if (i_tick && r_mode != M_IDLE) begin
            if (r_time > TIME_W'(1)) begin
                n_time = r_time - TIME_W'(1);
            end else begin
                case (r_mode)
                    M_CHASE: begin
                        if (!r_phase) begin
                            n_bits  = '0;
                            n_phase = 1'b1;
                            n_time  = load_time(i_cfg.chase_gap_ms);
                        end else begin
                            if (r_idx == CH_LAST) begin
                                v_idx = '0;
                                v_rnd = r_round + 3'd1;
                            end else begin
                                v_idx = r_idx + IDX_W'(1);
                            end
                            if (v_rnd >= CHASE_ROUNDS) begin
                                v_done = 1'b1;
                            end else begin
                                n_phase = 1'b0;
                                n_idx   = v_idx;
                                n_round = v_rnd;
                                n_bits  = chan_bit(v_idx);
                                n_time  = load_time(i_cfg.chase_on_ms);
                            end
                        end
                    end
                    M_BOUNCE: begin
                        n_phase = r_phase;
                        if (!r_phase) begin
                            if (r_idx != CH_LAST) begin
                                v_idx = r_idx + IDX_W'(1);
                            end else begin
                                n_phase = 1'b1;
                                v_idx   = CH_TURN;
                            end
                        end else if (r_idx != '0) begin
                            v_idx = r_idx - IDX_W'(1);
                        end else begin
                            v_rnd = r_round + 3'd1;
                            if (v_rnd >= BOUNCE_ROUNDS) begin
                                v_done = 1'b1;
                            end else begin
                                n_phase = 1'b0;
                                v_idx   = '0;
                            end
                        end
                        if (!v_done) begin
                            n_idx   = v_idx;
                            n_round = v_rnd;
                            n_bits  = chan_bit(v_idx);
                            n_time  = load_time(i_cfg.bounce_ms);
                        end
                    end
                    M_FLASH: begin
                        if (!r_phase) begin
                            n_bits  = '0;
                            n_phase = 1'b1;
                            n_time  = load_time(i_cfg.flash_ms);
                        end else begin
                            v_rnd = r_round + 3'd1;
                            if (v_rnd >= FLASH_COUNT) begin
                                v_done = 1'b1;
                            end else begin
                                n_round = v_rnd;
                                n_phase = 1'b0;
                                n_bits  = '1;
                                n_time  = load_time(i_cfg.flash_ms);
                            end
                        end
                    end
                    M_SHUT: begin
                        n_amp  = 1'b0;
                        v_done = 1'b1;
                    end
                    default: begin
                        v_done = 1'b1;
                    end
                endcase
            end
        end

        if (v_done) begin
            n_mode  = M_IDLE;
            n_bits  = '0;
            n_idx   = '0;
            n_round = '0;
            n_phase = 1'b0;
            n_time  = '0;
        end

        // Start the next queued command once nothing is running.
        if (i_step && n_mode == M_IDLE && i_head.avail) begin
            o_pop   = 1'b1;
            n_idx   = '0;
            n_round = '0;
            n_phase = 1'b0;
            case (i_head.entry.op)
                OP_PULSE: begin
                    n_mode = M_PULSE;
                    n_idx  = i_head.entry.chan;
                    n_bits = chan_bit(i_head.entry.chan);
                    n_time = load_time(i_cfg.pulse_ms);
                end
                OP_CHASE: begin
                    n_mode = M_CHASE;
                    n_bits = chan_bit('0);
                    n_time = load_time(i_cfg.chase_on_ms);
                end
                OP_BOUNCE: begin
                    n_mode = M_BOUNCE;
                    n_bits = chan_bit('0);
                    n_time = load_time(i_cfg.bounce_ms);
                end
                OP_FLASH: begin
                    n_mode = M_FLASH;
                    n_bits = '1;
                    n_time = load_time(i_cfg.flash_ms);
                end
                OP_SHUT: begin
                    n_mode = M_SHUT;
                    n_bits = '0;
                    n_mute = 1'b1;
                    n_time = load_time(i_cfg.mute_to_shutdown_ms);
                end
                OP_START: begin
                    n_mode = M_START;
                    n_mute = 1'b1;
                    n_amp  = 1'b1;
                    n_time = load_time(i_cfg.startup_settle_ms);
                end
                OP_UNMUTE: begin
                    if (n_amp && i_fault_ok) begin
                        n_mute = 1'b0;
                    end else begin
                        w_refused = 1'b1;
                    end
                end
                OP_MUTE: begin
                    n_mute = 1'b1;
                end
                default: begin
                    n_mute = r_mute;
                end
            endcase
        end

        o_lines.channel_drive  = n_bits;
        o_lines.amp_enable     = n_amp;
        o_lines.amp_mute       = n_mute;
        o_lines.busy_res       = (n_mode != M_IDLE);
        o_lines.unmute_refused = w_refused;
    end

endmodule

[src/output_pattern_command_sequencer.sv]
// Top level of the output pattern command sequencer: handshake, register port, result register.
// Depends on opcs_pkg, opcs_in_if, opcs_out_if, opcs_front, opcs_queue and opcs_back.
`timescale 1ns / 1ps

// The sequencer takes one input beat per clock cycle: either a command byte
// (func = 0) or a one millisecond tick (func = 1). Every accepted beat yields
// exactly one result beat, registered, so it appears on the output channel in
// the cycle after acceptance and holds there until the sink takes it. The
// input stays ready while that result waits as long as the sink takes it in
// the same cycle; a stalled sink holds the input off until the result moves.
// The whole step for one beat, from decoding the byte through the queue into
// the pattern engine and amplifier control, is combinational, and its result
// is registered together with the engine state when the beat is accepted.
// Known command bytes wait in an eight-entry queue; a byte that finds the
// queue full is dropped and flagged, and an unknown byte is ignored without
// a flag. While no timed pattern or delay runs, one queued command starts per
// beat, so a command that arrives at an idle block starts in its own beat.
// Registers are written through a plain write port at any index; indexes past
// the last register are ignored. Write them only while the block is idle.

module output_pattern_command_sequencer import opcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    opcs_in_if.sink              i_in,
    opcs_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data
);

    t_cfg   r_cfg;
    logic   r_out_valid;
    t_lines r_out_lines;
    logic   r_out_dropped;

    logic   w_step;
    logic   w_known;
    t_qent  w_entry;
    logic   w_push;
    logic   w_pop;
    logic   w_dropped;
    t_qhead w_head;
    t_lines w_lines;

    // A new beat is taken whenever the result register is empty or drains now.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_step     = i_in.valid && i_in.ready;
    assign w_push     = w_step && !i_in.func && w_known;

    // Register write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_ms            <= PULSE_MS_RST;
            r_cfg.chase_on_ms         <= CHASE_ON_MS_RST;
            r_cfg.chase_gap_ms        <= CHASE_GAP_RST;
            r_cfg.bounce_ms           <= BOUNCE_MS_RST;
            r_cfg.flash_ms            <= FLASH_MS_RST;
            r_cfg.mute_to_shutdown_ms <= SHUT_MS_RST;
            r_cfg.startup_settle_ms   <= SETTLE_MS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PULSE_MS:     r_cfg.pulse_ms            <= i_cfg_data;
                CFG_CHASE_ON_MS:  r_cfg.chase_on_ms         <= i_cfg_data;
                CFG_CHASE_GAP_MS: r_cfg.chase_gap_ms        <= i_cfg_data;
                CFG_BOUNCE_MS:    r_cfg.bounce_ms           <= i_cfg_data;
                CFG_FLASH_MS:     r_cfg.flash_ms            <= i_cfg_data;
                CFG_SHUT_MS:      r_cfg.mute_to_shutdown_ms <= i_cfg_data;
                CFG_SETTLE_MS:    r_cfg.startup_settle_ms   <= i_cfg_data;
                default:          r_cfg                     <= r_cfg;
            endcase
        end
    end

    // The front end classifies the byte; the queue decouples it from the engine.
    opcs_front u_front (
        .i_command (i_in.command),
        .o_known   (w_known),
        .o_entry   (w_entry)
    );

    opcs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_entry (w_entry),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_dropped    (w_dropped)
    );

    // The back end advances on ticks and starts queued commands.
    opcs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_tick     (i_in.func),
        .i_fault_ok (i_in.fault_ok),
        .i_cfg      (r_cfg),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_lines    (w_lines)
    );

    // Result register: holds the lines as they stand after the accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_lines   <= w_lines;
            r_out_dropped <= w_dropped;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.channel_drive   = r_out_lines.channel_drive;
    assign o_out.amp_enable      = r_out_lines.amp_enable;
    assign o_out.amp_mute        = r_out_lines.amp_mute;
    assign o_out.busy_res        = r_out_lines.busy_res;
    assign o_out.unmute_refused  = r_out_lines.unmute_refused;
    assign o_out.command_dropped = r_out_dropped;

endmodule

[verif/output_pattern_command_sequencer_tb.sv]
// Self-checking testbench for the output pattern command sequencer.
// Depends on opcs_pkg, opcs_in_if, opcs_out_if and the RTL top level.
`timescale 1ns / 1ps

module output_pattern_command_sequencer_tb;
    import opcs_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RUN_LIMIT_NS = 3_000_000;
    localparam int HOLD_CYCLES  = 48;
    localparam int DRAIN_CYCLES = 8;

    localparam logic FUNC_CMD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // A byte outside every command range, used to check that it is ignored.
    localparam logic [CMD_W-1:0] CMD_NOISE_TOP = 8'hFF;
    // Register index past the last register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    typedef enum int {
        PROF_SMALL,
        PROF_ZERO,
        PROF_MIXED,
        PROF_MAX
    } t_timing_profile;

    // One result beat, packed in the order of the output channel fields.
    typedef struct packed {
        logic [CHANNELS-1:0] drive;
        logic                amp_en;
        logic                amp_mute;
        logic                busy;
        logic                refused;
        logic                dropped;
    } t_line_state;

    // Predicts the line levels after each accepted input beat and checks the
    // result beats against them in order.
    class line_scoreboard;
        t_cfg                cfg;
        t_mode               mode;
        logic [IDX_W-1:0]    chan_idx;
        logic [2:0]          rounds;
        logic                phase;
        logic [TIME_W-1:0]   ticks_left;
        logic [CHANNELS-1:0] chan_on;
        logic                amp_on;
        logic                mute_on;
        logic [CMD_W-1:0]    cmd_fifo[$];
        t_line_state         expected_lines[$];
        int                  mismatches;
        int                  checked;
        int                  drops;
        int                  refusals;
        int                  actions_done;

        function new();
            cfg.pulse_ms            = PULSE_MS_RST;
            cfg.chase_on_ms         = CHASE_ON_MS_RST;
            cfg.chase_gap_ms        = CHASE_GAP_RST;
            cfg.bounce_ms           = BOUNCE_MS_RST;
            cfg.flash_ms            = FLASH_MS_RST;
            cfg.mute_to_shutdown_ms = SHUT_MS_RST;
            cfg.startup_settle_ms   = SETTLE_MS_RST;
            go_idle();
            amp_on       = 1'b0;
            mute_on      = 1'b1;
            mismatches   = 0;
            checked      = 0;
            drops        = 0;
            refusals     = 0;
            actions_done = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
            case (idx)
                CFG_PULSE_MS:     cfg.pulse_ms = val;
                CFG_CHASE_ON_MS:  cfg.chase_on_ms = val;
                CFG_CHASE_GAP_MS: cfg.chase_gap_ms = val;
                CFG_BOUNCE_MS:    cfg.bounce_ms = val;
                CFG_FLASH_MS:     cfg.flash_ms = val;
                CFG_SHUT_MS:      cfg.mute_to_shutdown_ms = val;
                CFG_SETTLE_MS:    cfg.startup_settle_ms = val;
                default: ;
            endcase
        endfunction

        // A phase programmed as zero ticks still lasts one tick.
        function logic [TIME_W-1:0] span(logic [TIME_W-1:0] d);
            return (d == '0) ? TIME_W'(1) : d;
        endfunction

        function logic [CHANNELS-1:0] lamp(logic [IDX_W-1:0] idx);
            return CHANNELS'(1) << idx;
        endfunction

        function bit is_known(logic [CMD_W-1:0] c);
            return (c >= CMD_PULSE_LO && c <= CMD_PULSE_HI) || c == CMD_ALL_OFF ||
                   c == CMD_CHASE || c == CMD_BOUNCE || c == CMD_FLASH ||
                   c == CMD_SHUTDOWN || c == CMD_STARTUP || c == CMD_UNMUTE ||
                   c == CMD_MUTE;
        endfunction

        function void go_idle();
            mode       = M_IDLE;
            chan_on    = '0;
            chan_idx   = '0;
            rounds     = '0;
            phase      = 1'b0;
            ticks_left = '0;
        endfunction

        // Starts one command taken from the queue; returns the refused flag.
        function logic launch(logic [CMD_W-1:0] c, logic fault_ok);
            chan_idx = '0;
            rounds   = '0;
            phase    = 1'b0;
            if (c >= CMD_PULSE_LO && c <= CMD_PULSE_HI) begin
                mode       = M_PULSE;
                chan_idx   = IDX_W'(c - CMD_PULSE_LO);
                chan_on    = lamp(chan_idx);
                ticks_left = span(cfg.pulse_ms);
            end else if (c == CMD_CHASE) begin
                mode       = M_CHASE;
                chan_on    = lamp('0);
                ticks_left = span(cfg.chase_on_ms);
            end else if (c == CMD_BOUNCE) begin
                mode       = M_BOUNCE;
                chan_on    = lamp('0);
                ticks_left = span(cfg.bounce_ms);
            end else if (c == CMD_FLASH) begin
                mode       = M_FLASH;
                chan_on    = '1;
                ticks_left = span(cfg.flash_ms);
            end else if (c == CMD_ALL_OFF || c == CMD_SHUTDOWN) begin
                chan_on    = '0;
                mute_on    = 1'b1;
                mode       = M_SHUT;
                ticks_left = span(cfg.mute_to_shutdown_ms);
            end else if (c == CMD_STARTUP) begin
                mute_on    = 1'b1;
                amp_on     = 1'b1;
                mode       = M_START;
                ticks_left = span(cfg.startup_settle_ms);
            end else if (c == CMD_UNMUTE) begin
                if (amp_on && fault_ok) begin
                    mute_on = 1'b0;
                end else begin
                    return 1'b1;
                end
            end else if (c == CMD_MUTE) begin
                mute_on = 1'b1;
            end
            return 1'b0;
        endfunction

        // Moves the running action on when its current phase has run out.
        function void advance();
            case (mode)
                M_CHASE: begin
                    if (!phase) begin
                        chan_on    = '0;
                        phase      = 1'b1;
                        ticks_left = span(cfg.chase_gap_ms);
                        return;
                    end
                    chan_idx = chan_idx + 1'b1;
                    if (chan_idx >= CHANNELS) begin
                        chan_idx = '0;
                        rounds   = rounds + 1'b1;
                    end
                    if (rounds >= CHASE_ROUNDS) begin
                        actions_done++;
                        go_idle();
                        return;
                    end
                    phase      = 1'b0;
                    chan_on    = lamp(chan_idx);
                    ticks_left = span(cfg.chase_on_ms);
                end
                M_BOUNCE: begin
                    if (!phase) begin
                        if (chan_idx + 1 < CHANNELS) begin
                            chan_idx = chan_idx + 1'b1;
                        end else begin
                            phase    = 1'b1;
                            chan_idx = CH_TURN;
                        end
                    end else if (chan_idx > 0) begin
                        chan_idx = chan_idx - 1'b1;
                    end else begin
                        rounds = rounds + 1'b1;
                        if (rounds >= BOUNCE_ROUNDS) begin
                            actions_done++;
                            go_idle();
                            return;
                        end
                        phase    = 1'b0;
                        chan_idx = '0;
                    end
                    chan_on    = lamp(chan_idx);
                    ticks_left = span(cfg.bounce_ms);
                end
                M_FLASH: begin
                    if (!phase) begin
                        chan_on    = '0;
                        phase      = 1'b1;
                        ticks_left = span(cfg.flash_ms);
                        return;
                    end
                    rounds = rounds + 1'b1;
                    if (rounds >= FLASH_COUNT) begin
                        actions_done++;
                        go_idle();
                        return;
                    end
                    phase      = 1'b0;
                    chan_on    = '1;
                    ticks_left = span(cfg.flash_ms);
                end
                M_SHUT: begin
                    amp_on = 1'b0;
                    actions_done++;
                    go_idle();
                end
                default: begin
                    actions_done++;
                    go_idle();
                end
            endcase
        endfunction

        function void predict_step(logic func, logic [CMD_W-1:0] code, logic fault_ok);
            t_line_state want;
            want = '0;
            if (func == FUNC_CMD) begin
                if (is_known(code)) begin
                    if (cmd_fifo.size() >= QUEUE_DEPTH) begin
                        want.dropped = 1'b1;
                        drops++;
                    end else begin
                        cmd_fifo.push_back(code);
                    end
                end
            end else if (mode != M_IDLE) begin
                if (ticks_left > 1) begin
                    ticks_left = ticks_left - 1'b1;
                end else begin
                    advance();
                end
            end
            if (mode == M_IDLE && cmd_fifo.size() > 0) begin
                want.refused = launch(cmd_fifo.pop_front(), fault_ok);
                if (want.refused) begin
                    refusals++;
                end
            end
            want.drive    = chan_on;
            want.amp_en   = amp_on;
            want.amp_mute = mute_on;
            want.busy     = (mode != M_IDLE);
            expected_lines.push_back(want);
        endfunction

        function void report(string why, t_line_state want, t_line_state got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR at result %0d, %s: expected drive=%b en=%b mute=%b busy=%b ",
                         checked, why, want.drive, want.amp_en, want.amp_mute, want.busy,
                         "refused=%b dropped=%b, got drive=%b en=%b mute=%b busy=%b ",
                         want.refused, want.dropped, got.drive, got.amp_en, got.amp_mute,
                         got.busy, "refused=%b dropped=%b", got.refused, got.dropped);
            end
        endfunction

        function void check_beat(t_line_state got);
            t_line_state want;
            if (expected_lines.size() == 0) begin
                report("no result was due", '0, got);
            end else begin
                want = expected_lines.pop_front();
                if (got.drive !== want.drive || got.amp_en !== want.amp_en ||
                    got.amp_mute !== want.amp_mute || got.busy !== want.busy ||
                    got.refused !== want.refused || got.dropped !== want.dropped) begin
                    report("field mismatch", want, got);
                end
            end
            checked++;
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TIME_W-1:0]    cfg_data;

    opcs_in_if  in_ch();
    opcs_out_if out_ch();

    line_scoreboard lines_sb = new();

    // Both the sender and the receiver insert random gaps while this is set;
    // some random phases clear it to get long runs of back-to-back beats.
    bit idle_on = 1'b1;
    int beats_sent = 0;
    int settings_used = 0;
    int burst_left = 0;

    output_pattern_command_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the handshake locks up.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout: the run did not complete within %0d ns.", RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    // Result side. Each beat waits a random number of cycles before ready is
    // raised. Twice during the run the sink holds off for a long stretch so
    // that the result register fills and the block has to stall its input.
    initial begin : result_sink
        int          stall;
        int          taken;
        t_line_state got;
        taken = 0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (taken == 400 || taken == 1200) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            got = {out_ch.channel_drive, out_ch.amp_enable, out_ch.amp_mute,
                   out_ch.busy_res, out_ch.unmute_refused, out_ch.command_dropped};
            lines_sb.check_beat(got);
            taken++;
        end
    end

    // Offers one input beat, starting at a falling edge, and returns at the
    // falling edge after it was accepted. Valid is left high there so that
    // the next beat can follow without a bubble; park_input lowers it.
    task automatic send_beat(input logic func, input logic [CMD_W-1:0] code,
                             input logic fault_ok);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.func     <= func;
        in_ch.command  <= code;
        in_ch.fault_ok <= fault_ok;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        lines_sb.predict_step(func, code, fault_ok);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] code, input logic fault_ok);
        send_beat(FUNC_CMD, code, fault_ok);
    endtask

    // The command field of a tick carries random bits; the block must not care.
    task automatic send_tick(input logic fault_ok);
        send_beat(FUNC_TICK, CMD_W'($urandom_range(0, 255)), fault_ok);
    endtask

    task automatic park_input();
        in_ch.valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        lines_sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_time(t_timing_profile prof);
        int r;
        r = $urandom_range(0, 99);
        case (prof)
            PROF_ZERO: return '0;
            PROF_MAX:  return '1;
            PROF_MIXED: begin
                // Mostly short phases so that patterns run to the end, with
                // zero and some longer values mixed in.
                if (r < 20) return '0;
                if (r < 30) return TIME_W'($urandom_range(20, 40));
                return TIME_W'($urandom_range(1, 6));
            end
            default: return TIME_W'($urandom_range(0, 4));
        endcase
    endfunction

    // Writes every register once the block has returned all results, so that
    // no beat is in flight while the timing changes.
    task automatic new_setting(input t_timing_profile prof);
        park_input();
        while (lines_sb.expected_lines.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        write_reg(CFG_PULSE_MS,     pick_time(prof));
        write_reg(CFG_CHASE_ON_MS,  pick_time(prof));
        write_reg(CFG_CHASE_GAP_MS, pick_time(prof));
        write_reg(CFG_BOUNCE_MS,    pick_time(prof));
        write_reg(CFG_FLASH_MS,     pick_time(prof));
        write_reg(CFG_SHUT_MS,      pick_time(prof));
        write_reg(CFG_SETTLE_MS,    pick_time(prof));
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_SPARE_IDX, TIME_W'($urandom_range(0, 1023)));
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Known commands, weighted toward amplifier control and single pulses,
    // which are short and keep the queue moving.
    function automatic logic [CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return CMD_UNMUTE;
        if (r < 30) return CMD_STARTUP;
        if (r < 35) return CMD_MUTE;
        if (r < 60) return CMD_PULSE_LO + CMD_W'($urandom_range(0, CHANNELS - 1));
        if (r < 68) return CMD_CHASE;
        if (r < 76) return CMD_BOUNCE;
        if (r < 84) return CMD_FLASH;
        if (r < 92) return CMD_SHUTDOWN;
        return CMD_ALL_OFF;
    endfunction

    // One random beat. Ticks dominate so that timed actions finish and the
    // queue drains; now and then a burst of commands without ticks overfills
    // the queue. Ignored bytes do not count toward the phase length.
    task automatic random_beat(inout int counted);
        int               r;
        logic [CMD_W-1:0] code;
        logic             fault_ok;
        fault_ok = ($urandom_range(0, 9) != 0);
        r = $urandom_range(0, 99);
        if (burst_left == 0 && r < 3) begin
            burst_left = $urandom_range(8, 14);
        end
        if (burst_left > 0) begin
            burst_left--;
            send_cmd(pick_command(), fault_ok);
            counted++;
        end else if (r < 55) begin
            send_tick(fault_ok);
            counted++;
        end else if (r < 62) begin
            code = CMD_W'($urandom_range(0, 255));
            send_cmd(code, fault_ok);
            if (lines_sb.is_known(code)) begin
                counted++;
            end
        end else begin
            send_cmd(pick_command(), fault_ok);
            counted++;
        end
    endtask

    initial begin : stimulus
        t_timing_profile plan[8];
        int              counted;
        int              quota;
        plan = '{PROF_SMALL, PROF_MIXED, PROF_ZERO, PROF_SMALL,
                 PROF_MIXED, PROF_SMALL, PROF_MIXED, PROF_MAX};

        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_PULSE_MS;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.func     = FUNC_CMD;
        in_ch.command  = CMD_ALL_OFF;
        in_ch.fault_ok = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with the reset timing. A tick while idle changes
        // nothing, an unmute with the amplifier off is refused, and bytes
        // outside every command range are ignored without a flag.
        send_tick(1'b1);
        send_cmd(CMD_UNMUTE, 1'b1);
        send_cmd(CMD_NOISE_TOP, 1'b1);
        send_cmd(CMD_PULSE_HI + 8'd1, 1'b0);
        send_cmd(CMD_FLASH + 8'd1, 1'b1);
        send_cmd(CMD_MUTE + 8'd1, 1'b1);
        // The start-up holds the engine busy, so the next eight commands fill
        // the queue and the two after them are dropped and flagged.
        send_cmd(CMD_STARTUP, 1'b1);
        send_cmd(CMD_UNMUTE, 1'b0);
        send_cmd(CMD_PULSE_LO, 1'b1);
        send_cmd(CMD_PULSE_HI, 1'b1);
        send_cmd(CMD_CHASE, 1'b1);
        send_cmd(CMD_BOUNCE, 1'b1);
        send_cmd(CMD_FLASH, 1'b1);
        send_cmd(CMD_MUTE, 1'b1);
        send_cmd(CMD_ALL_OFF, 1'b1);
        send_cmd(CMD_SHUTDOWN, 1'b1);
        send_cmd(CMD_PULSE_LO + 8'd1, 1'b1);

        // Zero durations for the ticks below; queued patterns then step once per tick.
        new_setting(PROF_ZERO);
        repeat (3) begin
            send_tick(1'b0);
            send_tick(1'b1);
        end

        // Random phases, each under its own register setting. Every third
        // phase runs without gaps on either side. The all-ones setting comes
        // last, since a single phase of it outlasts a whole random phase.
        for (int p = 0; p < 8; p++) begin
            new_setting(plan[p]);
            idle_on = (p % 3 != 2);
            quota   = (plan[p] == PROF_MAX) ? 100 : 215;
            counted = 0;
            while (counted < quota) begin
                random_beat(counted);
            end
        end

        park_input();
        while (lines_sb.expected_lines.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d input beats, %0d results checked, %0d register settings.",
                 beats_sent, lines_sb.checked, settings_used);
        $display("Summary: %0d drops on a full queue, %0d refused unmutes, %0d timed actions done.",
                 lines_sb.drops, lines_sb.refusals, lines_sb.actions_done);
        if (lines_sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Mismatches: %0d", lines_sb.mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/opcs_pkg.sv
src/opcs_in_if.sv
src/opcs_out_if.sv
src/opcs_front.sv
src/opcs_queue.sv
src/opcs_back.sv
src/output_pattern_command_sequencer.sv
verif/output_pattern_command_sequencer_tb.sv
